/* hw/rtl/ppmhps_pkg.sv */
// ----------------------------------------------------------------------------
// ppmhps_pkg
// Shared types, byte codes and field layout for the P6 header parser and
// plane splitter.
// ----------------------------------------------------------------------------
package ppmhps_pkg;

   localparam int DIM_BITS_DEFAULT = 16;
   localparam int OUT_DIM_BITS     = 16;
   localparam int PIX_BITS         = 32;

   localparam int REQ_DATA_BITS = 8;
   localparam int REQ_USER_BITS = 1;
   localparam int RSP_DATA_BITS = 64;
   localparam int RSP_USER_BITS = 3;

   // rsp_tdata layout
   localparam int RSP_ERR_LSB  = 8;
   localparam int RSP_ERR_MSB  = 10;
   localparam int RSP_DONE_BIT = 11;
   localparam int RSP_PAD_BITS = RSP_DATA_BITS - (8 + 3 + 1 + 3 * OUT_DIM_BITS);

   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_SIX   = 8'h36;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [2:0] {
      DEST_HEADER  = 3'd0,
      DEST_RED     = 3'd1,
      DEST_GREEN   = 3'd2,
      DEST_BLUE    = 3'd3,
      DEST_DISCARD = 3'd4
   } dest_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_MAGIC_P   = 3'd1,
      ERR_MAGIC_6   = 3'd2,
      ERR_MAGIC_SEP = 3'd3,
      ERR_WIDTH     = 3'd4,
      ERR_HEIGHT    = 3'd5,
      ERR_MAXVAL    = 3'd6,
      ERR_TRUNC     = 3'd7
   } err_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_file;
   } req_beat_type;

   typedef struct packed {
      dest_type                out_dest;
      logic [7:0]              out_byte;
      err_type                 error_code;
      logic                    image_done;
      logic [OUT_DIM_BITS-1:0] width_seen;
      logic [OUT_DIM_BITS-1:0] height_seen;
      logic [OUT_DIM_BITS-1:0] maxval_seen;
   } rsp_item_type;

   function automatic logic is_sep(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

endpackage

/* hw/rtl/ppmhps_in_stage.sv */
// ----------------------------------------------------------------------------
// ppmhps_in_stage
// Input register: holds one request beat until the parser takes it.
// ----------------------------------------------------------------------------
module ppmhps_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // in_byte
   input  logic                      req_tuser,   // end_of_file
   input  logic                      take,
   output logic                      beat_valid,
   output ppmhps_pkg::req_beat_type  beat
);
   import ppmhps_pkg::*;

   logic         valid_ff, valid_in;
   req_beat_type beat_ff, beat_in;

   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (req_tvalid && req_tready) begin
         valid_in            = 1'b1;
         beat_in.in_byte     = req_tdata;
         beat_in.end_of_file = req_tuser;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

/* hw/rtl/ppmhps_parser.sv */
// ----------------------------------------------------------------------------
// ppmhps_parser
// Header parse state, dimension accumulators, pixel counter and the
// per-byte next-state and tagging logic.
// ----------------------------------------------------------------------------
module ppmhps_parser #(
   parameter int DIM_BITS = ppmhps_pkg::DIM_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  ppmhps_pkg::req_beat_type  beat,
   output ppmhps_pkg::rsp_item_type  item
);
   import ppmhps_pkg::*;

   localparam int PROD_BITS = 2 * DIM_BITS;
   localparam int EXT_BITS  = (PROD_BITS > PIX_BITS) ? PROD_BITS : PIX_BITS + 1;
   localparam logic [DIM_BITS-1:0] DIM_MAX = '1;

   typedef enum logic [9:0] {
      PH_MAGIC_P   = 10'b00_0000_0001,
      PH_MAGIC_6   = 10'b00_0000_0010,
      PH_MAGIC_SEP = 10'b00_0000_0100,
      PH_W_FIRST   = 10'b00_0000_1000,
      PH_WIDTH     = 10'b00_0001_0000,
      PH_HEIGHT    = 10'b00_0010_0000,
      PH_MAXVAL    = 10'b00_0100_0000,
      PH_PIXELS    = 10'b00_1000_0000,
      PH_DONE      = 10'b01_0000_0000,
      PH_ERROR     = 10'b10_0000_0000
   } phase_type;

   function automatic logic [DIM_BITS-1:0] acc_digit(input logic [DIM_BITS-1:0] acc,
                                                      input logic [7:0] b);
      logic [DIM_BITS+3:0] v;
      v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (DIM_BITS + 4)'(b[3:0]);
      return (v > {4'b0, DIM_MAX}) ? DIM_MAX : v[DIM_BITS-1:0];
   endfunction

   phase_type            phase_ff, phase_in;
   logic                 comment_ff, comment_in;
   logic [DIM_BITS-1:0]  width_ff, width_in;
   logic [DIM_BITS-1:0]  height_ff, height_in;
   logic [DIM_BITS-1:0]  maxval_ff, maxval_in;
   logic [PIX_BITS-1:0]  pixels_ff, pixels_in;
   logic [1:0]           chan_ff, chan_in;
   err_type              err_ff, err_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;

   logic [EXT_BITS-1:0]  prod_ext;
   logic [PIX_BITS-1:0]  pix_total;
   logic [PIX_BITS-1:0]  pix_dec;
   logic [7:0]           b;
   dest_type             dest;
   logic [7:0]           obyte;

   // width and height settle at least one beat before the maxval separator
   assign prod_in   = PROD_BITS'(width_ff) * PROD_BITS'(height_ff);
   assign prod_ext  = EXT_BITS'(prod_ff);
   assign pix_total = (|prod_ext[EXT_BITS-1:PIX_BITS]) ? '1 : prod_ext[PIX_BITS-1:0];
   assign pix_dec   = (pixels_ff != '0) ? pixels_ff - PIX_BITS'(1) : '0;
   assign b         = beat.in_byte;

   always_comb begin
      phase_in   = phase_ff;
      comment_in = comment_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      maxval_in  = maxval_ff;
      pixels_in  = pixels_ff;
      chan_in    = chan_ff;
      err_in     = err_ff;
      dest       = DEST_DISCARD;
      obyte      = '0;
      if (beat.end_of_file) begin
         if (phase_ff != PH_DONE && phase_ff != PH_ERROR) begin
            err_in   = ERR_TRUNC;
            phase_in = PH_ERROR;
         end
      end else begin
         obyte = b;
         unique case (phase_ff)
            PH_DONE, PH_ERROR: begin
               dest = DEST_DISCARD;
            end
            PH_PIXELS: begin
               dest = dest_type'(DEST_RED + {1'b0, chan_ff});
               if (chan_ff >= 2'd2) begin
                  chan_in   = 2'd0;
                  pixels_in = pix_dec;
                  if (pix_dec == '0) begin
                     phase_in = PH_DONE;
                  end
               end else begin
                  chan_in = chan_ff + 2'd1;
               end
            end
            default: begin
               dest = DEST_HEADER;
               if ((phase_ff == PH_MAGIC_P || phase_ff == PH_W_FIRST) &&
                   (comment_ff || b == CH_HASH)) begin
                  comment_in = (b != CH_LF);
               end else begin
                  unique case (phase_ff)
                     PH_MAGIC_P: begin
                        if (b == CH_P) begin
                           phase_in = PH_MAGIC_6;
                        end else begin
                           err_in   = ERR_MAGIC_P;
                           phase_in = PH_ERROR;
                        end
                     end
                     PH_MAGIC_6: begin
                        if (b == CH_SIX) begin
                           phase_in = PH_MAGIC_SEP;
                        end else begin
                           err_in   = ERR_MAGIC_6;
                           phase_in = PH_ERROR;
                        end
                     end
                     PH_MAGIC_SEP: begin
                        if (is_sep(b)) begin
                           phase_in = PH_W_FIRST;
                        end else begin
                           err_in   = ERR_MAGIC_SEP;
                           phase_in = PH_ERROR;
                        end
                     end
                     PH_W_FIRST, PH_WIDTH: begin
                        if (is_digit(b)) begin
                           phase_in = PH_WIDTH;
                           width_in = acc_digit(width_ff, b);
                        end else if (is_sep(b)) begin
                           phase_in = PH_HEIGHT;
                        end else begin
                           err_in   = ERR_WIDTH;
                           phase_in = PH_ERROR;
                        end
                     end
                     PH_HEIGHT: begin
                        if (is_digit(b)) begin
                           height_in = acc_digit(height_ff, b);
                        end else if (is_sep(b)) begin
                           phase_in = PH_MAXVAL;
                        end else begin
                           err_in   = ERR_HEIGHT;
                           phase_in = PH_ERROR;
                        end
                     end
                     default: begin
                        if (is_digit(b)) begin
                           maxval_in = acc_digit(maxval_ff, b);
                        end else if (is_sep(b)) begin
                           pixels_in = pix_total;
                           chan_in   = 2'd0;
                           phase_in  = (pix_total == '0) ? PH_DONE : PH_PIXELS;
                        end else begin
                           err_in   = ERR_MAXVAL;
                           phase_in = PH_ERROR;
                        end
                     end
                  endcase
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAGIC_P;
         comment_ff <= 1'b0;
         width_ff   <= '0;
         height_ff  <= '0;
         maxval_ff  <= '0;
         pixels_ff  <= '0;
         chan_ff    <= 2'd0;
         err_ff     <= ERR_NONE;
      end else if (step) begin
         phase_ff   <= phase_in;
         comment_ff <= comment_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         maxval_ff  <= maxval_in;
         pixels_ff  <= pixels_in;
         chan_ff    <= chan_in;
         err_ff     <= err_in;
      end
      prod_ff <= prod_in;
   end

   always_comb begin
      item.out_dest    = dest;
      item.out_byte    = obyte;
      item.error_code  = err_in;
      item.image_done  = (phase_in == PH_DONE);
      item.width_seen  = OUT_DIM_BITS'(width_in);
      item.height_seen = OUT_DIM_BITS'(height_in);
      item.maxval_seen = OUT_DIM_BITS'(maxval_in);
   end

endmodule

/* hw/rtl/ppmhps_out_stage.sv */
// ----------------------------------------------------------------------------
// ppmhps_out_stage
// Result register: holds one response beat until the sink takes it.
// ----------------------------------------------------------------------------
module ppmhps_out_stage (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  ppmhps_pkg::rsp_item_type              item,
   output logic                                  space,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // out_byte, error_code, image_done, width_seen, height_seen, maxval_seen
   output logic [ppmhps_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // out_dest
   output logic [ppmhps_pkg::RSP_USER_BITS-1:0]  rsp_tuser
);
   import ppmhps_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   assign space = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = item;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = item_ff.out_dest;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, item_ff.maxval_seen, item_ff.height_seen,
                        item_ff.width_seen, item_ff.image_done, item_ff.error_code,
                        item_ff.out_byte};

endmodule

/* hw/rtl/ppm_header_parse_and_plane_split.sv */
// ----------------------------------------------------------------------------
// ppm_header_parse_and_plane_split
// Binary PPM (P6) header parser and color plane splitter, one byte per beat.
// ----------------------------------------------------------------------------
// Takes one byte per clock, with no bubbles while the sink keeps rsp_tready
// high, and returns one tagged beat per input beat through the input register
// and then the result register. The per-byte parse is a single pass of logic
// between the two registers; the width*height pixel count comes from a
// registered multiplier that runs in the background while maxval is parsed, so
// it never holds up the stream. Errors are sticky; only reset starts a new
// image.
module ppm_header_parse_and_plane_split #(
   parameter int DIM_BITS = ppmhps_pkg::DIM_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // in_byte
   input  logic [ppmhps_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // end_of_file
   input  logic [ppmhps_pkg::REQ_USER_BITS-1:0]  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // out_byte, error_code, image_done, width_seen, height_seen, maxval_seen
   output logic [ppmhps_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // out_dest
   output logic [ppmhps_pkg::RSP_USER_BITS-1:0]  rsp_tuser
);
   import ppmhps_pkg::*;

   logic         beat_valid;
   req_beat_type beat;
   logic         space;
   logic         step;
   rsp_item_type item;

   assign step = beat_valid && space;

   ppmhps_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser[0]),
      .take       (step),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   ppmhps_parser #(
      .DIM_BITS (DIM_BITS)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .beat  (beat),
      .item  (item)
   );

   ppmhps_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .item       (item),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* hw/rtl/ppmhps_checker.sv */
// ----------------------------------------------------------------------------
// ppmhps_checker
// Port-level checks for the P6 parser, bound to the top level.
// ----------------------------------------------------------------------------
module ppmhps_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [ppmhps_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic [ppmhps_pkg::RSP_USER_BITS-1:0]  rsp_tuser
);
   import ppmhps_pkg::*;

   // stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   // no beat comes out of reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // done and an error never show together
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_DONE_BIT] |->
         rsp_tdata[RSP_ERR_MSB:RSP_ERR_LSB] == ERR_NONE)
      else $error("image done with an error latched");

   // pixel beats only while error free
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == DEST_RED || rsp_tuser == DEST_GREEN ||
                     rsp_tuser == DEST_BLUE) |->
         rsp_tdata[RSP_ERR_MSB:RSP_ERR_LSB] == ERR_NONE)
      else $error("pixel beat tagged after an error");

endmodule

bind ppm_header_parse_and_plane_split ppmhps_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
